[hw/rtl/mlfp_pkg.sv]
// ----------------------------------------------------------------------------
// mlfp_pkg
// Shared constants and types for the magic/length frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfp_pkg;

  localparam int COUNT_WIDTH = 21;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int MAXLEN_W    = 21;

  localparam logic [31:0]         MAGIC_RESET  = 32'hEFD2_BB99;
  localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = MAXLEN_W'(1024 * 1024);

  localparam logic [3:0]  HDR_LAST = 4'd13;
  localparam logic [31:0] LEN_BIAS = 32'd10;
  localparam logic [31:0] MIN_LEN  = 32'd11;

  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_WORD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = CFG_IDX_W'(1);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_HALTED  = 2'd2;

  localparam logic [1:0] ST_PAYLOAD   = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_TOO_SMALL = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [7:0]  compress_kind;
    logic [7:0]  encrypt_kind;
    logic [31:0] frame_version;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/magic_length_frame_parser.sv]
// ----------------------------------------------------------------------------
// magic_length_frame_parser
// Byte-stream frame parser: 14-byte header, magic and length checks, payload.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_byte) carries one stream byte per
// transaction. The first 14 bytes of a frame form the header; they produce no
// result. A good header is followed by length-10 payload bytes, each returned
// on the output channel with first/last marks and the header fields.
// A failed check returns one error transaction and the block then swallows
// every further byte without a result until reset.
// Each result is registered in the output buffer before it reaches the outputs.
// Throughput: one byte per cycle, bounded only by the output handshake.
// When out_ready is low, a skid entry absorbs one more result; in_ready drops
// only while both the result register and the skid entry are full.
// Reset (rst_n low, synchronous) returns to header collection, empties the
// output, and restores magic_word and max_length to their defaults.
// Configuration writes (cfg_we) take effect at once; write them while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module magic_length_frame_parser (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [mlfp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mlfp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire logic [7:0]                       in_byte,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic [1:0]                       out_status,
  output      logic [7:0]                       out_byte,
  output      logic                             out_first_byte,
  output      logic                             out_last_byte,
  output      logic [7:0]                       out_compress_kind,
  output      logic [7:0]                       out_encrypt_kind,
  output      logic [31:0]                      out_frame_version
);

  logic              byte_fire;
  logic              res_valid;
  mlfp_pkg::result_t res;
  mlfp_pkg::result_t out_data;

  assign byte_fire = in_valid && in_ready;

  mlfp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .byte_fire (byte_fire),
    .byte_in   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  mlfp_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_status        = out_data.status;
  assign out_byte          = out_data.data;
  assign out_first_byte    = out_data.first;
  assign out_last_byte     = out_data.last;
  assign out_compress_kind = out_data.compress_kind;
  assign out_encrypt_kind  = out_data.encrypt_kind;
  assign out_frame_version = out_data.frame_version;

endmodule

`default_nettype wire

[hw/rtl/mlfp_parse.sv]
// ----------------------------------------------------------------------------
// mlfp_parse
// Header collection, frame checks and payload counting, one byte per cycle while byte_fire is high.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfp_parse (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [mlfp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mlfp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                               byte_fire,
  input  wire logic [7:0]                         byte_in,
  output      logic                               res_valid,
  output      mlfp_pkg::result_t                  res
);

  logic [31:0]                        magic_word_r;
  logic [mlfp_pkg::MAXLEN_W-1:0]      max_length_r;
  logic [1:0]                         phase_r, phase_nxt;
  logic [3:0]                         hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]                        magic_acc_r, magic_acc_nxt;
  logic [31:0]                        length_acc_r, length_acc_nxt;
  logic [7:0]                         compress_r, compress_nxt;
  logic [7:0]                         encrypt_r, encrypt_nxt;
  logic [31:0]                        version_acc_r, version_acc_nxt;
  logic [mlfp_pkg::COUNT_WIDTH-1:0]   left_r, left_nxt;
  logic                               first_r, first_nxt;
  logic [31:0]                        len_diff;
  logic                               last_hit;

  assign len_diff = length_acc_r - mlfp_pkg::LEN_BIAS;
  assign last_hit = (left_r <= mlfp_pkg::COUNT_WIDTH'(1));

  always_comb begin
    phase_nxt       = phase_r;
    hdr_cnt_nxt     = hdr_cnt_r;
    magic_acc_nxt   = magic_acc_r;
    length_acc_nxt  = length_acc_r;
    compress_nxt    = compress_r;
    encrypt_nxt     = encrypt_r;
    version_acc_nxt = version_acc_r;
    left_nxt        = left_r;
    first_nxt       = first_r;
    res_valid       = 1'b0;
    res.status      = mlfp_pkg::ST_PAYLOAD;
    res.data        = 8'd0;
    res.first       = 1'b0;
    res.last        = 1'b0;
    res.compress_kind = compress_r;
    res.encrypt_kind  = encrypt_r;
    res.frame_version = version_acc_r;
    if (byte_fire) begin
      unique case (phase_r)
        mlfp_pkg::PH_HEADER: begin
          if (hdr_cnt_r < 4'd4) begin
            magic_acc_nxt = {magic_acc_r[23:0], byte_in};
          end else if (hdr_cnt_r < 4'd8) begin
            length_acc_nxt = {length_acc_r[23:0], byte_in};
          end else if (hdr_cnt_r == 4'd8) begin
            compress_nxt = byte_in;
          end else if (hdr_cnt_r == 4'd9) begin
            encrypt_nxt = byte_in;
          end else begin
            version_acc_nxt = {version_acc_r[23:0], byte_in};
          end
          res.frame_version = version_acc_nxt;
          if (hdr_cnt_r != mlfp_pkg::HDR_LAST) begin
            hdr_cnt_nxt = hdr_cnt_r + 4'd1;
          end else begin
            hdr_cnt_nxt = 4'd0;
            priority if (magic_acc_r != magic_word_r) begin
              phase_nxt  = mlfp_pkg::PH_HALTED;
              res_valid  = 1'b1;
              res.status = mlfp_pkg::ST_BAD_MAGIC;
            end else if (length_acc_r > 32'(max_length_r)) begin
              phase_nxt  = mlfp_pkg::PH_HALTED;
              res_valid  = 1'b1;
              res.status = mlfp_pkg::ST_TOO_LARGE;
            end else if (length_acc_r < mlfp_pkg::MIN_LEN) begin
              phase_nxt  = mlfp_pkg::PH_HALTED;
              res_valid  = 1'b1;
              res.status = mlfp_pkg::ST_TOO_SMALL;
            end else begin
              left_nxt  = len_diff[mlfp_pkg::COUNT_WIDTH-1:0];
              first_nxt = 1'b1;
              phase_nxt = (len_diff[mlfp_pkg::COUNT_WIDTH-1:0] == '0) ?
                          mlfp_pkg::PH_HEADER : mlfp_pkg::PH_PAYLOAD;
            end
          end
        end
        mlfp_pkg::PH_PAYLOAD: begin
          res_valid  = 1'b1;
          res.status = mlfp_pkg::ST_PAYLOAD;
          res.data   = byte_in;
          res.first  = first_r;
          res.last   = last_hit;
          first_nxt  = 1'b0;
          if (last_hit) begin
            left_nxt  = '0;
            phase_nxt = mlfp_pkg::PH_HEADER;
          end else begin
            left_nxt = left_r - mlfp_pkg::COUNT_WIDTH'(1);
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_word_r <= mlfp_pkg::MAGIC_RESET;
      max_length_r <= mlfp_pkg::MAXLEN_RESET;
    end else if (cfg_we) begin
      if (cfg_index == mlfp_pkg::REG_MAGIC_WORD) begin
        magic_word_r <= cfg_wdata;
      end else if (cfg_index == mlfp_pkg::REG_MAX_LENGTH) begin
        max_length_r <= cfg_wdata[mlfp_pkg::MAXLEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= mlfp_pkg::PH_HEADER;
      hdr_cnt_r     <= 4'd0;
      magic_acc_r   <= '0;
      length_acc_r  <= '0;
      compress_r    <= '0;
      encrypt_r     <= '0;
      version_acc_r <= '0;
      left_r        <= '0;
      first_r       <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      hdr_cnt_r     <= hdr_cnt_nxt;
      magic_acc_r   <= magic_acc_nxt;
      length_acc_r  <= length_acc_nxt;
      compress_r    <= compress_nxt;
      encrypt_r     <= encrypt_nxt;
      version_acc_r <= version_acc_nxt;
      left_r        <= left_nxt;
      first_r       <= first_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mlfp_outbuf.sv]
// ----------------------------------------------------------------------------
// mlfp_outbuf
// Result register with a skid entry; the upstream ready is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfp_outbuf (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire mlfp_pkg::result_t  push_data,
  output      logic               can_push,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      mlfp_pkg::result_t  out_data
);

  logic              main_v_r, main_v_nxt;
  logic              skid_v_r, skid_v_nxt;
  mlfp_pkg::result_t main_d_r, main_d_nxt;
  mlfp_pkg::result_t skid_d_r, skid_d_nxt;
  logic              pop;

  assign pop       = main_v_r && out_ready;
  assign can_push  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_d_nxt = main_d_r;
    skid_d_nxt = skid_d_r;
    if (pop) begin
      main_v_nxt = 1'b0;
    end
    if (pop && skid_v_r) begin
      main_v_nxt = 1'b1;
      main_d_nxt = skid_d_r;
      skid_v_nxt = 1'b0;
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_v_nxt = 1'b1;
        main_d_nxt = push_data;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/mlfp_chk.sv]
// ----------------------------------------------------------------------------
// mlfp_chk
// Port-level checks for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfp_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status,
  input wire logic [7:0] out_byte,
  input wire logic       out_first_byte,
  input wire logic       out_last_byte
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output dropped while stalled");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != mlfp_pkg::ST_PAYLOAD |->
      out_byte == 8'd0 && !out_first_byte && !out_last_byte)
    else $error("error transaction carries payload marks");

  a_marks_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_first_byte || out_last_byte) |->
      out_status == mlfp_pkg::ST_PAYLOAD)
    else $error("first/last mark on a non-payload transaction");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_status != mlfp_pkg::ST_PAYLOAD |=> !out_valid)
    else $error("transaction after an error");

endmodule

bind magic_length_frame_parser mlfp_chk u_mlfp_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_byte       (out_byte),
  .out_first_byte (out_first_byte),
  .out_last_byte  (out_last_byte)
);

`default_nettype wire

[bench/mlfp_frame_checker.sv]
// ----------------------------------------------------------------------------
// mlfp_frame_checker
// Watches the parser's configuration port and both stream channels, keeps
// its own model of the header collection, the magic/length checks and the
// payload counter, and compares every result transaction with the oldest
// predicted one. Mismatches and the number of results still owed are handed
// to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlfp_frame_checker
  import mlfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [1:0]            out_status,
  input  logic [7:0]            out_byte,
  input  logic                  out_first_byte,
  input  logic                  out_last_byte,
  input  logic [7:0]            out_compress_kind,
  input  logic [7:0]            out_encrypt_kind,
  input  logic [31:0]           out_frame_version,
  output int                    mismatches,
  output int                    results_checked,
  output int                    results_owed
);

  logic [1:0]             parse_phase;
  logic [3:0]             hdr_idx;
  logic [31:0]            magic_sh;
  logic [31:0]            length_sh;
  logic [31:0]            version_sh;
  logic [7:0]             compress_q;
  logic [7:0]             encrypt_q;
  logic [COUNT_WIDTH-1:0] bytes_left;
  logic [31:0]            magic_cfg;
  logic [MAXLEN_W-1:0]    max_len_cfg;
  result_t                predicted_out[$];

  task automatic queue_result(input result_t r);
    predicted_out.insert(predicted_out.size(), r);
  endtask

  task automatic parse_byte(input logic [7:0] b);
    result_t                r;
    logic [COUNT_WIDTH-1:0] total;
    r = '0;
    r.compress_kind = compress_q;
    r.encrypt_kind  = encrypt_q;
    r.frame_version = version_sh;
    if (parse_phase == PH_HEADER) begin
      if (hdr_idx < 4'd4) begin
        magic_sh = {magic_sh[23:0], b};
      end else if (hdr_idx < 4'd8) begin
        length_sh = {length_sh[23:0], b};
      end else if (hdr_idx == 4'd8) begin
        compress_q = b;
      end else if (hdr_idx == 4'd9) begin
        encrypt_q = b;
      end else begin
        version_sh = {version_sh[23:0], b};
      end
      if (hdr_idx != HDR_LAST) begin
        hdr_idx = hdr_idx + 4'd1;
      end else begin
        hdr_idx = '0;
        r.compress_kind = compress_q;
        r.encrypt_kind  = encrypt_q;
        r.frame_version = version_sh;
        if (magic_sh != magic_cfg) begin
          parse_phase = PH_HALTED;
          r.status = ST_BAD_MAGIC;
          queue_result(r);
        end else if (length_sh > 32'(max_len_cfg)) begin
          parse_phase = PH_HALTED;
          r.status = ST_TOO_LARGE;
          queue_result(r);
        end else if (length_sh < MIN_LEN) begin
          parse_phase = PH_HALTED;
          r.status = ST_TOO_SMALL;
          queue_result(r);
        end else begin
          bytes_left  = COUNT_WIDTH'(length_sh - LEN_BIAS);
          parse_phase = (bytes_left == '0) ? PH_HEADER : PH_PAYLOAD;
        end
      end
    end else if (parse_phase == PH_PAYLOAD) begin
      total    = COUNT_WIDTH'(length_sh - LEN_BIAS);
      r.status = ST_PAYLOAD;
      r.data   = b;
      r.first  = (bytes_left == total);
      r.last   = (bytes_left <= COUNT_WIDTH'(1));
      queue_result(r);
      if (r.last) begin
        bytes_left  = '0;
        parse_phase = PH_HEADER;
      end else begin
        bytes_left = bytes_left - COUNT_WIDTH'(1);
      end
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t seen;
    if (!rst_n) begin
      parse_phase = PH_HEADER;
      hdr_idx     = '0;
      magic_sh    = '0;
      length_sh   = '0;
      version_sh  = '0;
      compress_q  = '0;
      encrypt_q   = '0;
      bytes_left  = '0;
      magic_cfg   = MAGIC_RESET;
      max_len_cfg = MAXLEN_RESET;
      predicted_out.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen.status        = out_status;
        seen.data          = out_byte;
        seen.first         = out_first_byte;
        seen.last          = out_last_byte;
        seen.compress_kind = out_compress_kind;
        seen.encrypt_kind  = out_encrypt_kind;
        seen.frame_version = out_frame_version;
        results_checked++;
        if (predicted_out.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result st=%0d byte=%02h f=%0b l=%0b", $time,
                     seen.status, seen.data, seen.first, seen.last);
          mismatches++;
        end else begin
          want = predicted_out.pop_front();
          if (seen.status !== want.status || seen.data !== want.data ||
              seen.first !== want.first || seen.last !== want.last ||
              seen.compress_kind !== want.compress_kind ||
              seen.encrypt_kind !== want.encrypt_kind ||
              seen.frame_version !== want.frame_version) begin
            if (mismatches < 10)
              $display({"%0t: mismatch exp st=%0d byte=%02h f=%0b l=%0b c=%02h e=%02h ",
                        "v=%08h / got st=%0d byte=%02h f=%0b l=%0b c=%02h e=%02h v=%08h"},
                       $time, want.status, want.data, want.first, want.last,
                       want.compress_kind, want.encrypt_kind, want.frame_version,
                       seen.status, seen.data, seen.first, seen.last,
                       seen.compress_kind, seen.encrypt_kind, seen.frame_version);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_MAGIC_WORD) begin
          magic_cfg = cfg_wdata;
        end else if (cfg_index == REG_MAX_LENGTH) begin
          max_len_cfg = cfg_wdata[MAXLEN_W-1:0];
        end
      end
      if (in_valid && in_ready) begin
        parse_byte(in_byte);
      end
    end
    results_owed = predicted_out.size();
  end

endmodule

[bench/magic_length_frame_parser_tb.sv]
// ----------------------------------------------------------------------------
// magic_length_frame_parser_tb
// Drives byte streams of well-formed frames into the parser under a series
// of magic and max-length settings, with random idle gaps on both channels,
// one long receiver hold-off and drained pauses for register writes. The run
// ends with one frame that fails a header check, followed by bytes the halted
// parser must drop. Checking is done by mlfp_frame_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module magic_length_frame_parser_tb
  import mlfp_pkg::*;
();

  localparam int PHASE_BYTES     = 250;
  localparam int HOLD_OFF_CYCLES = 64;
  localparam int DRAIN_TAIL      = 4;
  localparam int END_TAIL        = 10;
  localparam int WATCHDOG_LIMIT  = 2000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            out_status;
  logic [7:0]            out_byte;
  logic                  out_first_byte;
  logic                  out_last_byte;
  logic [7:0]            out_compress_kind;
  logic [7:0]            out_encrypt_kind;
  logic [31:0]           out_frame_version;

  int          mismatches;
  int          results_checked;
  int          results_owed;
  int          idle_cycles;
  int          bytes_sent;
  int          settings_used;
  int unsigned cur_magic;
  int unsigned cur_max;
  bit          src_idle_on;
  bit          sink_idle_on;
  logic        hold_off_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  magic_length_frame_parser u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_byte          (out_byte),
    .out_first_byte    (out_first_byte),
    .out_last_byte     (out_last_byte),
    .out_compress_kind (out_compress_kind),
    .out_encrypt_kind  (out_encrypt_kind),
    .out_frame_version (out_frame_version)
  );

  mlfp_frame_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_byte          (out_byte),
    .out_first_byte    (out_first_byte),
    .out_last_byte     (out_last_byte),
    .out_compress_kind (out_compress_kind),
    .out_encrypt_kind  (out_encrypt_kind),
    .out_frame_version (out_frame_version),
    .mismatches        (mismatches),
    .results_checked   (results_checked),
    .results_owed      (results_owed)
  );

  function automatic int idle_len(input bit on);
    int unsigned roll;
    if (!on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned pick_length(input int unsigned max_len);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return (max_len > 300) ? $urandom_range(41, 300) : max_len;
    if (roll == 1) return MIN_LEN;
    return $urandom_range(MIN_LEN, (max_len > 40) ? 40 : max_len);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_len(src_idle_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
  endtask

  task automatic send_header(input logic [31:0] magic, input logic [31:0] length,
                             input logic [7:0] comp, input logic [7:0] enc,
                             input logic [31:0] ver);
    send_word(magic);
    send_word(length);
    send_byte(comp);
    send_byte(enc);
    send_word(ver);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // receiver side: random back-pressure plus one long hold-off on request
  initial begin : result_sink
    int hold;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req <= 1'b0;
        out_ready    <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        hold = idle_len(sink_idle_on);
        if (hold > 0) begin
          out_ready <= 1'b0;
          repeat (hold) @(posedge clk);
        end else begin
          out_ready <= 1'b1;
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a transaction", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int          phase_start;
    int          kind;
    int unsigned len;
    int unsigned mx;
    logic [31:0] m;
    string       err_name;

    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_byte   <= '0;
    cur_magic    = MAGIC_RESET;
    cur_max      = MAXLEN_RESET;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // writes to spare indexes must leave both registers untouched
    write_reg(REG_SPARE_2, $urandom);
    write_reg(REG_SPARE_3, $urandom);

    // single-byte payload, then a two-byte one; field extremes in the headers
    send_header(MAGIC_RESET, MIN_LEN, 8'hFF, 8'h00, 32'hFFFF_FFFF);
    send_byte(8'h00);
    send_header(MAGIC_RESET, MIN_LEN + 1, 8'h00, 8'hFF, 32'h0000_0000);
    send_byte(8'hFF);
    send_byte(8'h5A);

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin
          m = MAGIC_RESET; mx = MAXLEN_RESET;
          src_idle_on = 1'b1; sink_idle_on = 1'b1;
        end
        1: begin
          m = 32'h0000_0000; mx = MIN_LEN;
          src_idle_on = 1'b0; sink_idle_on = 1'b0;
        end
        2: begin
          m = 32'hFFFF_FFFF; mx = MAXLEN_RESET;
          src_idle_on = 1'b1; sink_idle_on = 1'b0;
        end
        3: begin
          m = $urandom; mx = $urandom_range(11, 200);
          src_idle_on = 1'b0; sink_idle_on = 1'b1;
        end
        4: begin
          m = $urandom; mx = $urandom_range(12, 64);
          src_idle_on = 1'b1; sink_idle_on = 1'b1;
        end
        default: begin
          m = MAGIC_RESET; mx = MAXLEN_RESET;
          src_idle_on = 1'b1; sink_idle_on = 1'b1;
        end
      endcase
      write_reg(REG_MAGIC_WORD, m);
      write_reg(REG_MAX_LENGTH, mx);
      cur_magic = m;
      cur_max   = mx;
      settings_used++;
      phase_start = bytes_sent;

      if (p == 2) begin
        // keep offering bytes while the receiver holds off
        src_idle_on   = 1'b0;
        hold_off_req <= 1'b1;
        send_header(cur_magic, 160, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom);
        repeat (150) send_byte($urandom_range(0, 255));
        src_idle_on = 1'b1;
      end

      if (p == 4) begin
        // length exactly at the configured limit
        send_header(cur_magic, cur_max, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom);
        repeat (cur_max - LEN_BIAS) send_byte($urandom_range(0, 255));
      end

      while (bytes_sent - phase_start < PHASE_BYTES) begin
        len = pick_length(cur_max);
        send_header(cur_magic, len, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom);
        repeat (len - LEN_BIAS) send_byte($urandom_range(0, 255));
      end
    end

    // one failing header, then bytes the halted parser must drop
    drain();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    kind = $urandom_range(0, 3);
    case (kind)
      0: begin
        err_name = "bad magic";
        m = cur_magic ^ (32'h1 << $urandom_range(0, 31));
        len = $urandom;
      end
      1: begin
        err_name = "length over limit";
        m = cur_magic;
        len = $urandom_range(0, 1) ? 32'hFFFF_FFFF : cur_max + 1 + $urandom_range(0, 1000);
      end
      2: begin
        err_name = "length under minimum";
        m = cur_magic;
        len = $urandom_range(0, 10);
      end
      default: begin
        err_name = "limit below minimum";
        mx = $urandom_range(0, 10);
        write_reg(REG_MAX_LENGTH, mx);
        settings_used++;
        m = cur_magic;
        len = $urandom_range(0, 1) ? $urandom_range(0, 10) : $urandom;
      end
    endcase
    send_header(m, len, $urandom_range(0, 255), $urandom_range(0, 255), $urandom);
    repeat (20) send_byte($urandom_range(0, 255));
    drain();
    repeat (END_TAIL) @(posedge clk);

    $display("run: %0d stream bytes, %0d results checked, %0d register settings",
             bytes_sent, results_checked, settings_used);
    $display("run: closing frame failed on %s; later bytes were dropped", err_name);
    if (mismatches == 0 && results_owed == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
